### rtl/core/swsfd_pkg.sv
// Shared types and constants for the single-wire sensor frame decoder.
// No dependencies; imported by the decoder top level and the bench.
package swsfd_pkg;

   localparam int NumBytes = 5;

   // Pulse count at which data bits start (the first two are preamble).
   localparam logic [5:0] PREAMBLE_PULSES = 6'd3;
   localparam logic [5:0] PULSE_MAX       = 6'd63;

   localparam logic [7:0] ZERO_LIMIT_RST = 8'd30;
   localparam logic [7:0] ONE_LIMIT_RST  = 8'd85;
   localparam logic [7:0] IDLE_LIMIT_RST = 8'd200;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [1:0] {
      REG_ZERO_LIMIT = 2'd0,
      REG_ONE_LIMIT  = 2'd1,
      REG_IDLE_LIMIT = 2'd2
   } reg_index_type;

   typedef enum logic {
      CAUSE_IDLE     = 1'b0,
      CAUSE_OVERLONG = 1'b1
   } end_cause_type;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic               frame_ok;
      end_cause_type      end_cause;
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
      logic [7:0]         checksum_byte;
   } result_type;

endpackage

### rtl/core/swsfd_if.sv
// Valid/ready channel interfaces: line sample beats, frame results, register writes.
// No dependencies.
interface swsfd_req_if;
   logic valid;
   logic ready;
   logic line_level;
   logic arm;

   modport source (output valid, line_level, arm, input ready);
   modport sink   (input valid, line_level, arm, output ready);
endinterface

interface swsfd_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_ok;
   logic               end_cause;
   logic [15:0]        humidity_tenths;
   logic signed [15:0] temperature_tenths;
   logic [7:0]         checksum_byte;

   modport source (output valid, frame_ok, end_cause, humidity_tenths,
                   temperature_tenths, checksum_byte, input ready);
   modport sink   (input valid, frame_ok, end_cause, humidity_tenths,
                   temperature_tenths, checksum_byte, output ready);
endinterface

interface swsfd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] reg_index;
   logic [7:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/core/single_wire_sensor_frame_decoder_unit.sv
// Single-wire sensor frame decoder: pulse timing, bit/byte assembly, checksum and scaling.
// Depends on swsfd_pkg and the channel interfaces in swsfd_if.sv.
//
//  channel | dir | payload                                            | accepted when
//  --------+-----+----------------------------------------------------+---------------
//  req_ch  | in  | line_level, arm                                    | valid & ready
//  rsp_ch  | out | frame_ok, end_cause, humidity/temperature, checksum| valid & ready
//  csr_ch  | in  | reg_index (0 zero, 1 one, 2 idle limit), wr_data   | valid & ready
//
// One sample beat per cycle while req_ch is ready; decoder state updates at the accepting edge.
// The ending beat's result goes to the output register, or to the skid entry on a stall.
// Results pass through a two-entry output register/skid pair; req_ch stalls only
// when both entries are full. csr_ch is always ready.
// Synchronous reset restores limit defaults and leaves the decoder disarmed.
module single_wire_sensor_frame_decoder_unit
   import swsfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   swsfd_req_if.sink    req_ch,
   swsfd_rsp_if.source  rsp_ch,
   swsfd_csr_if.sink    csr_ch
);

   // limit registers
   logic [7:0] zero_limit_ff, one_limit_ff, idle_limit_ff;

   // decoder state
   logic       armed_ff, armed_in;
   logic [7:0] high_run_ff, high_run_in;
   logic [5:0] pulse_count_ff, pulse_count_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [3:0] bit_count_ff, bit_count_in;
   byte_type   frame_bytes_ff [NumBytes];
   byte_type   frame_bytes_in [NumBytes];

   // output stage
   result_type out_ff, skid_ff;
   logic       rsp_valid_ff, skid_valid_ff;

   logic       req_fire, rsp_fire;
   logic       finish;
   end_cause_type cause;
   result_type result;

   // state as seen after an arm request on this beat
   logic       a_armed;
   logic [7:0] a_high;
   logic [5:0] a_pc;
   logic [7:0] a_sh;
   logic [3:0] a_bc;
   byte_type   a_bytes [NumBytes];

   logic [7:0] hr_inc;
   logic       bit_val;
   logic [2:0] byte_slot;
   logic [7:0] sum8;
   logic       sum_ok;
   logic [14:0] mag;

   assign req_fire      = req_ch.valid && req_ch.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_ch.ready;
   assign req_ch.ready  = !skid_valid_ff;
   assign csr_ch.ready  = 1'b1;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_limit_ff <= ZERO_LIMIT_RST;
         one_limit_ff  <= ONE_LIMIT_RST;
         idle_limit_ff <= IDLE_LIMIT_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            REG_ZERO_LIMIT: zero_limit_ff <= csr_ch.wr_data;
            REG_ONE_LIMIT:  one_limit_ff  <= csr_ch.wr_data;
            REG_IDLE_LIMIT: idle_limit_ff <= csr_ch.wr_data;
            default: ;
         endcase
      end
   end

   // ---------------- decode ----------------
   always_comb begin
      a_armed = armed_ff || req_ch.arm;
      a_high  = req_ch.arm ? 8'd0 : high_run_ff;
      a_pc    = req_ch.arm ? 6'd0 : pulse_count_ff;
      a_sh    = req_ch.arm ? 8'd0 : shift_byte_ff;
      a_bc    = req_ch.arm ? 4'd0 : bit_count_ff;
      for (int i = 0; i < NumBytes; i++) begin
         a_bytes[i] = req_ch.arm ? 8'd0 : frame_bytes_ff[i];
      end

      armed_in       = a_armed;
      high_run_in    = a_high;
      pulse_count_in = a_pc;
      shift_byte_in  = a_sh;
      bit_count_in   = a_bc;
      frame_bytes_in = a_bytes;
      finish         = 1'b0;
      cause          = CAUSE_IDLE;
      hr_inc         = a_high + 8'd1;
      bit_val        = 1'b0;
      byte_slot      = 3'd0;

      if (a_armed) begin
         if (req_ch.line_level) begin
            high_run_in = hr_inc;
            if (hr_inc >= idle_limit_ff) begin
               finish      = 1'b1;
               cause       = CAUSE_IDLE;
               armed_in    = 1'b0;
               high_run_in = 8'd0;
            end
         end else if (a_high != 8'd0) begin
            if (a_high >= zero_limit_ff && a_high >= one_limit_ff) begin
               finish      = 1'b1;
               cause       = CAUSE_OVERLONG;
               armed_in    = 1'b0;
               high_run_in = 8'd0;
            end else begin
               bit_val        = (a_high >= zero_limit_ff);
               high_run_in    = 8'd0;
               shift_byte_in  = {a_sh[6:0], bit_val};
               bit_count_in   = a_bc + 4'd1;
               pulse_count_in = (a_pc < PULSE_MAX) ? a_pc + 6'd1 : a_pc;
               if (pulse_count_in < PREAMBLE_PULSES) begin
                  shift_byte_in = 8'd0;
                  bit_count_in  = 4'd0;
               end
               if (bit_count_in >= BITS_PER_BYTE) begin
                  // byte k completes at pulse count 8*(k+1)+2
                  byte_slot = pulse_count_in[5:3];
                  for (int i = 0; i < NumBytes; i++) begin
                     if (byte_slot == 3'(i + 1)) frame_bytes_in[i] = shift_byte_in;
                  end
                  shift_byte_in = 8'd0;
                  bit_count_in  = 4'd0;
               end
            end
         end
      end
   end

   // checksum and scaling over the bytes held at frame end
   always_comb begin
      sum8   = a_bytes[0] + a_bytes[1] + a_bytes[2] + a_bytes[3];
      sum_ok = (a_bytes[4] == sum8) && (sum8 != 8'd0);
      mag    = {a_bytes[2][6:0], a_bytes[3]};
      result.frame_ok        = sum_ok;
      result.end_cause       = cause;
      result.checksum_byte   = a_bytes[4];
      result.humidity_tenths = sum_ok ? {a_bytes[0], a_bytes[1]} : 16'd0;
      if (!sum_ok)
         result.temperature_tenths = 16'sd0;
      else if (a_bytes[2][7])
         result.temperature_tenths = -$signed({1'b0, mag});
      else
         result.temperature_tenths = $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         high_run_ff    <= 8'd0;
         pulse_count_ff <= 6'd0;
         shift_byte_ff  <= 8'd0;
         bit_count_ff   <= 4'd0;
         for (int i = 0; i < NumBytes; i++) frame_bytes_ff[i] <= 8'd0;
      end else if (req_fire) begin
         armed_ff       <= armed_in;
         high_run_ff    <= high_run_in;
         pulse_count_ff <= pulse_count_in;
         shift_byte_ff  <= shift_byte_in;
         bit_count_ff   <= bit_count_in;
         frame_bytes_ff <= frame_bytes_in;
      end
   end

   // ---------------- output register + skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_fire && finish;
         end
      end else if (req_fire && finish) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_fire) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (rsp_valid_ff && !rsp_fire && !skid_valid_ff) begin
         skid_ff <= result;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.frame_ok           = out_ff.frame_ok;
   assign rsp_ch.end_cause          = out_ff.end_cause;
   assign rsp_ch.humidity_tenths    = out_ff.humidity_tenths;
   assign rsp_ch.temperature_tenths = out_ff.temperature_tenths;
   assign rsp_ch.checksum_byte      = out_ff.checksum_byte;

   // ---------------- checks ----------------
   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty output register");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ch.ready))
      else $error("skid filled while output was draining");

   a_result_from_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("result appeared without an accepted beat");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff < BITS_PER_BYTE)
      else $error("bit counter left a completed byte unflushed");

   a_idle_no_run: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> high_run_ff == 8'd0)
      else $error("high run counter active while disarmed");

endmodule

### sim/single_wire_sensor_frame_decoder_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the single-wire sensor frame decoder: drives line sample beats,
// register writes and a stalling result sink. It predicts every frame result internally.
// Depends on swsfd_pkg, the channel interfaces in swsfd_if.sv and the decoder top level.
module single_wire_sensor_frame_decoder_unit_test
   import swsfd_pkg::*;
();

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 64;

   // Opening beats, leftmost first: ignored samples, arm on a high sample, preamble,
   // one 0 bit, one 1 bit, an overlong pulse, then re-arm on a high sample and idle out.
   localparam bit [0:24] OPENING_LEVEL = 25'b10101_10101_11011_11001_11111;
   localparam bit [0:24] OPENING_ARM   = 25'b00100_00000_00000_00001_00000;

   // Limit sets per phase: zero_limit, one_limit, idle_limit and frames sent.
   int phase_zero   [8] = '{3, 1, 255, 6, 0, 2, 30, 4};
   int phase_one    [8] = '{6, 2, 255, 3, 0, 5, 85, 9};
   int phase_idle   [8] = '{10, 255, 255, 12, 4, 0, 200, 16};
   int phase_frames [8] = '{1, 1, 1, 1, 3, 3, 1, 1};

   class frame_result_book;
      byte_type   zero_lim, one_lim, idle_lim;
      bit         armed;
      byte_type   high_run;
      bit [5:0]   pulse_count;
      byte_type   shift_byte;
      bit [3:0]   bit_count;
      byte_type   frame_bytes [NumBytes];
      result_type awaited [$];
      int errors, decoded, frames, ok_frames, idle_ends, overlong_ends, limit_writes;

      function new();
         zero_lim = ZERO_LIMIT_RST;
         one_lim  = ONE_LIMIT_RST;
         idle_lim = IDLE_LIMIT_RST;
         armed = 1'b0;
         clear_frame();
      endfunction

      function void clear_frame();
         high_run = '0;
         pulse_count = '0;
         shift_byte = '0;
         bit_count = '0;
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
      endfunction

      function void write_limit(reg_index_type idx, byte_type value);
         limit_writes++;
         case (idx)
            REG_ZERO_LIMIT: zero_lim = value;
            REG_ONE_LIMIT:  one_lim  = value;
            REG_IDLE_LIMIT: idle_lim = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void close_frame(end_cause_type cause);
         byte_type    sum;
         logic [15:0] mag;
         result_type  r;
         sum = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
         r = '0;
         r.frame_ok = (frame_bytes[4] == sum) && (sum != 8'd0);
         r.end_cause = cause;
         r.checksum_byte = frame_bytes[4];
         if (r.frame_ok) begin
            r.humidity_tenths = {frame_bytes[0], frame_bytes[1]};
            mag = {1'b0, frame_bytes[2][6:0], frame_bytes[3]};
            r.temperature_tenths = frame_bytes[2][7] ? 16'd0 - mag : mag;
            ok_frames++;
         end
         if (cause == CAUSE_IDLE) idle_ends++;
         else overlong_ends++;
         frames++;
         armed = 1'b0;
         high_run = '0;
         awaited.push_back(r);
      endfunction

      // One accepted sample beat.
      function void take_sample(bit level, bit arm);
         int slot;
         if (arm) begin
            clear_frame();
            armed = 1'b1;
         end
         if (!armed) return;
         decoded++;
         if (level) begin
            high_run = high_run + 8'd1;
            if (high_run >= idle_lim) close_frame(CAUSE_IDLE);
            return;
         end
         if (high_run == 8'd0) return;
         // zero_limit wins when the limits overlap
         if (high_run < zero_lim) shift_byte = {shift_byte[6:0], 1'b0};
         else if (high_run < one_lim) shift_byte = {shift_byte[6:0], 1'b1};
         else begin
            close_frame(CAUSE_OVERLONG);
            return;
         end
         high_run = '0;
         bit_count++;
         if (pulse_count < PULSE_MAX) pulse_count++;
         if (pulse_count < PREAMBLE_PULSES) begin
            shift_byte = '0;
            bit_count = '0;
         end
         if (bit_count >= BITS_PER_BYTE) begin
            slot = int'(pulse_count >> 3);
            if (slot >= 1 && slot <= NumBytes) frame_bytes[slot - 1] = shift_byte;
            shift_byte = '0;
            bit_count = '0;
         end
      endfunction

      function void match_frame(result_type seen);
         result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected frame result: ok=%0b cause=%0b hum=%0d temp=%0d csum=%0d",
                        seen.frame_ok, seen.end_cause, seen.humidity_tenths,
                        seen.temperature_tenths, seen.checksum_byte);
            return;
         end
         want = awaited.pop_front();
         if (want.frame_ok !== seen.frame_ok || want.end_cause !== seen.end_cause ||
             want.humidity_tenths !== seen.humidity_tenths ||
             want.temperature_tenths !== seen.temperature_tenths ||
             want.checksum_byte !== seen.checksum_byte) begin
            errors++;
            if (errors <= 10) begin
               $display("frame mismatch: expected ok=%0b cause=%0b hum=%0d temp=%0d csum=%0d",
                        want.frame_ok, want.end_cause, want.humidity_tenths,
                        want.temperature_tenths, want.checksum_byte);
               $display("                  actual ok=%0b cause=%0b hum=%0d temp=%0d csum=%0d",
                        seen.frame_ok, seen.end_cause, seen.humidity_tenths,
                        seen.temperature_tenths, seen.checksum_byte);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   swsfd_req_if req_ch ();
   swsfd_rsp_if rsp_ch ();
   swsfd_csr_if csr_ch ();

   single_wire_sensor_frame_decoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   frame_result_book book = new();

   int         cycle_count = 0;
   int         req_gap_pct = 0;
   int         rsp_stall_pct = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   int         hold_requests = 0;
   int         holds_done = 0;
   bit         calm = 1'b0;
   result_type rsp_beat;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result sink: random stall bursts, plus long holds requested by the stimulus.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_beat.frame_ok = rsp_ch.frame_ok;
            rsp_beat.end_cause = end_cause_type'(rsp_ch.end_cause);
            rsp_beat.humidity_tenths = rsp_ch.humidity_tenths;
            rsp_beat.temperature_tenths = rsp_ch.temperature_tenths;
            rsp_beat.checksum_byte = rsp_ch.checksum_byte;
            book.match_frame(rsp_beat);
         end
         if (!calm && $urandom_range(0, 199) == 0) begin
            case ($urandom_range(0, 2))
               0: rsp_stall_pct = 0;
               1: rsp_stall_pct = 15;
               default: rsp_stall_pct = 40;
            endcase
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(bit level, bit arm);
      int gap;
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.line_level <= level;
      req_ch.arm <= arm;
      do @(posedge clock); while (!req_ch.ready);
      book.take_sample(level, arm);
   endtask

   task automatic send_run(bit level, int n);
      repeat (n) send_beat(level, 1'b0);
   endtask

   // Leaves csr valid high; set_limits lowers it after the last beat.
   task automatic put_reg(reg_index_type idx, byte_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      book.write_limit(idx, value);
   endtask

   task automatic set_limits(int zl, int ol, int il);
      put_reg(REG_ZERO_LIMIT, byte_type'(zl));
      put_reg(REG_ONE_LIMIT, byte_type'(ol));
      put_reg(REG_IDLE_LIMIT, byte_type'(il));
      csr_ch.valid <= 1'b0;
   endtask

   // Sender pause: everything outstanding drains before the next phase.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // High time that decodes as the wanted bit, falling back to the other class
   // when the current limits leave no room for it.
   function automatic int pulse_width(bit one_bit);
      int lo0, hi0, lo1, hi1, lo, hi;
      bit use_one;
      lo0 = 1;
      hi0 = int'(book.zero_lim) - 1;
      lo1 = (book.zero_lim > 1) ? int'(book.zero_lim) : 1;
      hi1 = int'(book.one_lim) - 1;
      use_one = one_bit;
      if (use_one && hi1 < lo1) use_one = 1'b0;
      if (!use_one && hi0 < lo0) use_one = 1'b1;
      lo = use_one ? lo1 : lo0;
      hi = use_one ? hi1 : hi0;
      if (hi < lo) return 1;
      if (hi > lo + 3) hi = lo + 3;
      return $urandom_range(hi, lo);
   endfunction

   task automatic send_frame();
      byte_type data [NumBytes];
      int       kind, n_bits, w;
      bit       b;
      if (!calm) begin
         case ($urandom_range(0, 3))
            0, 1: req_gap_pct = 0;
            2: req_gap_pct = 10;
            default: req_gap_pct = 30;
         endcase
      end
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) data[i] = byte_type'($urandom);
      if ($urandom_range(0, 9) == 0) for (int i = 0; i < 4; i++) data[i] = '0;
      data[4] = data[0] + data[1] + data[2] + data[3];
      if ($urandom_range(0, 4) == 0) data[4] = byte_type'($urandom);

      if ($urandom_range(0, 3) == 0)
         send_run(1'($urandom_range(0, 1)), $urandom_range(1, 3));
      send_beat($urandom_range(0, 3) == 0, 1'b1);
      if (kind == 9) begin
         // noise with stray arms
         repeat ($urandom_range(5, 60))
            send_beat(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
         return;
      end
      send_run(1'b0, $urandom_range(1, 3));
      repeat (2) begin
         send_run(1'b1, pulse_width(1'($urandom_range(0, 1))));
         send_run(1'b0, $urandom_range(1, 3));
      end
      if (kind == 7) n_bits = $urandom_range(0, 39);
      else if (kind == 8) n_bits = 40 + $urandom_range(1, 30);
      else n_bits = 40;
      for (int i = 0; i < n_bits; i++) begin
         b = (i < 40) ? data[i / 8][7 - (i % 8)] : 1'($urandom_range(0, 1));
         send_run(1'b1, pulse_width(b));
         send_run(1'b0, $urandom_range(1, 3));
      end
      if ($urandom_range(0, 1)) begin
         send_run(1'b1, (book.idle_lim > 0) ? int'(book.idle_lim) : 1);
      end else begin
         w = (book.zero_lim > book.one_lim) ? int'(book.zero_lim) : int'(book.one_lim);
         if (w < 1) w = 1;
         send_run(1'b1, w + $urandom_range(0, 2));
         send_beat(1'b0, 1'b0);
      end
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.line_level = 1'b0;
      req_ch.arm = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = REG_ZERO_LIMIT;
      csr_ch.wr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_limits(2, 4, 6);
      for (int k = 0; k < 25; k++) send_beat(OPENING_LEVEL[k], OPENING_ARM[k]);

      for (int k = 0; k < 8; k++) begin
         settle();
         set_limits(phase_zero[k], phase_one[k], phase_idle[k]);
         repeat (phase_frames[k]) send_frame();
         if (phase_idle[k] == 0) begin
            // every armed high beat ends a frame: results pile up behind the hold
            req_gap_pct = 0;
            hold_requests++;
            repeat (12) send_beat(1'b1, 1'b1);
         end
      end

      settle();
      set_limits(3, 6, 10);
      calm = 1'b1;
      rsp_stall_pct = 0;
      req_gap_pct = 0;
      n = 0;
      while (book.decoded < 2000 || n < 1) begin
         send_frame();
         n++;
      end
      settle();
      repeat (16) @(posedge clock);

      $display("covered %0d decoded sample beats over %0d limit writes and 10 limit sets",
               book.decoded, book.limit_writes);
      $display("frames: %0d total, %0d checksum ok, %0d idle ended, %0d overlong; %0d errors",
               book.frames, book.ok_frames, book.idle_ends, book.overlong_ends, book.errors);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
